### sv/fcf_pkg.sv
// Shared constants and hand-off types for the 4-tap full-convolution FIR.
`timescale 1ns / 1ps

package fcf_pkg;

    localparam int TAPS_DEFAULT        = 4;
    localparam int SAMPLE_BITS_DEFAULT = 16;
    localparam int COEF_BITS           = 16;
    localparam int OUT_BITS            = 34;
    // Wide enough to address the largest supported kernel (8 taps).
    localparam int CFG_INDEX_BITS      = 3;

    // Control that travels with each transaction from cell to cell.
    typedef struct packed {
        logic valid;
        logic last;
    } xfer_ctl_t;

endpackage

### sv/full_convolution_fir_4tap_top.sv
// Top level of the streaming full-convolution FIR: coefficients, feed and cell chain.
`timescale 1ns / 1ps

// Streaming FIR that computes the full convolution of each sample block with a
// TAPS-long kernel (default 4). It takes one signed sample per cycle and returns
// the exact 34-bit sum coef_0*x[n] + coef_1*x[n-1] + ... for every sample. A
// transaction with block_end set is followed by TAPS-1 tail results computed
// with zeros shifted in; the final tail result carries last_out, and the delay
// line is left all zeros for the next block. Throughput is one transaction per
// clock while the output does not stall; each block end holds in_stall high
// while the feed sequencer pushes tail zeros through the chain's single entry.
// Input reaches the output through one register per multiply-accumulate cell;
// each cell holds one transaction, and bubbles close up when the output stalls,
// so the input keeps taking samples until the chain is full. Coefficients must
// be written through cfg_we/cfg_index/cfg_data while the filter is idle; the
// block does not enforce this. An index at or beyond TAPS is ignored. With
// TAPS = 1 the sample's own result carries last_out on a block end.
module full_convolution_fir_4tap_top #(
    parameter int TAPS        = fcf_pkg::TAPS_DEFAULT,
    parameter int SAMPLE_BITS = fcf_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // coefficient write port
    input  logic                                  cfg_we,
    input  logic [fcf_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [fcf_pkg::COEF_BITS-1:0]         cfg_data,
    // input channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [SAMPLE_BITS-1:0]         sample,
    input  logic                                  block_end,
    // output channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [fcf_pkg::OUT_BITS-1:0]   filtered,
    output logic                                  last_out
);

    // Kernel weights, one register per tap.
    logic signed [fcf_pkg::COEF_BITS-1:0] coef_reg [TAPS];

    // Chain hand-off: position k feeds cell k, position TAPS is the output.
    fcf_pkg::xfer_ctl_t               ctl_chain   [TAPS+1];
    logic [fcf_pkg::OUT_BITS-1:0]     sum_chain   [TAPS+1];
    logic [TAPS-1:0][SAMPLE_BITS-1:0] taps_chain  [TAPS+1];
    logic                             ready_chain [TAPS+1];

    // Write a coefficient; drop writes to indexes beyond the kernel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < TAPS; k++)
            begin
                coef_reg[k] <= '0;
            end
        end
        else
        begin
            for (int k = 0; k < TAPS; k++)
            begin
                if (cfg_we && (cfg_index == fcf_pkg::CFG_INDEX_BITS'(k)))
                begin
                    coef_reg[k] <= cfg_data;
                end
            end
        end
    end

    // Feed sequencer: accepts samples, keeps the history, inserts tail zeros.
    fcf_feed #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_feed (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .block_end  (block_end),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .down_ready (ready_chain[0]),
        .feed_ctl   (ctl_chain[0]),
        .feed_taps  (taps_chain[0])
    );

    assign sum_chain[0] = '0;

    // Cell k adds coef_k times the tap k steps back to the running sum.
    generate
        for (genvar k = 0; k < TAPS; k++)
        begin : g_cell
            fcf_cell #(
                .TAPS        (TAPS),
                .SAMPLE_BITS (SAMPLE_BITS),
                .IDX         (k)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .coef       (coef_reg[k]),
                .up_ctl     (ctl_chain[k]),
                .up_sum     (sum_chain[k]),
                .up_taps    (taps_chain[k]),
                .up_ready   (ready_chain[k]),
                .down_ready (ready_chain[k+1]),
                .dn_ctl     (ctl_chain[k+1]),
                .dn_sum     (sum_chain[k+1]),
                .dn_taps    (taps_chain[k+1])
            );
        end
    endgenerate

    // The last cell's register is the output register; advance it when taken.
    assign ready_chain[TAPS] = !out_stall;

    assign out_valid = ctl_chain[TAPS].valid;
    assign filtered  = sum_chain[TAPS];
    assign last_out  = ctl_chain[TAPS].last;

endmodule

### sv/fcf_feed.sv
// Input sequencer: sample history, tail zero insertion and input handshake.
`timescale 1ns / 1ps

module fcf_feed #(
    parameter int TAPS        = fcf_pkg::TAPS_DEFAULT,
    parameter int SAMPLE_BITS = fcf_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic signed [SAMPLE_BITS-1:0]      sample,
    input  logic                               block_end,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               down_ready,
    output fcf_pkg::xfer_ctl_t                 feed_ctl,
    output logic [TAPS-1:0][SAMPLE_BITS-1:0]   feed_taps
);

    localparam int CNT_W = (TAPS > 1) ? $clog2(TAPS) : 1;

    logic [CNT_W-1:0]       tail_cnt_reg;
    logic [CNT_W-1:0]       tail_cnt_next;
    logic                   tail_active;
    logic                   shift;
    logic [SAMPLE_BITS-1:0] x;

    assign tail_active = (tail_cnt_reg != '0);
    assign in_stall    = tail_active || !down_ready;
    assign shift       = (tail_active || in_valid) && down_ready;
    assign x           = tail_active ? '0 : sample;

    assign feed_ctl.valid = tail_active || in_valid;
    assign feed_ctl.last  = tail_active ? (tail_cnt_reg == CNT_W'(1))
                                        : (block_end && (TAPS == 1));

    assign feed_taps[0] = x;

    always_comb
    begin
        tail_cnt_next = tail_cnt_reg;
        if (shift)
        begin
            if (tail_active)
            begin
                tail_cnt_next = tail_cnt_reg - CNT_W'(1);
            end
            else if (block_end && (TAPS > 1))
            begin
                tail_cnt_next = CNT_W'(TAPS - 1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_cnt_reg <= '0;
        end
        else
        begin
            tail_cnt_reg <= tail_cnt_next;
        end
    end

    generate
        if (TAPS > 1)
        begin : g_hist
            logic [TAPS-2:0][SAMPLE_BITS-1:0] hist_reg;
            logic [TAPS-2:0][SAMPLE_BITS-1:0] hist_next;

            always_comb
            begin
                hist_next    = hist_reg;
                if (shift)
                begin
                    hist_next[0] = x;
                    for (int k = 1; k < TAPS - 1; k++)
                    begin
                        hist_next[k] = hist_reg[k-1];
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    hist_reg <= '0;
                end
                else
                begin
                    hist_reg <= hist_next;
                end
            end

            for (genvar k = 1; k < TAPS; k++)
            begin : g_tap
                assign feed_taps[k] = hist_reg[k-1];
            end

            // Tail flush leaves the delay line cleared.
            a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
                (tail_cnt_reg == CNT_W'(1)) && shift |=> (hist_reg == '0))
                else $error("history not cleared after tail flush");
        end
    endgenerate

    // Hold the input side while tail zeros go out.
    a_tail_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        tail_active |-> in_stall)
        else $error("input accepted during tail flush");

    // A block end arms the full tail.
    a_tail_armed: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && block_end && (TAPS > 1)
            |=> (tail_cnt_reg == CNT_W'(TAPS - 1)))
        else $error("tail counter not armed on block end");

endmodule

### sv/fcf_cell.sv
// One multiply-accumulate cell of the FIR chain.
`timescale 1ns / 1ps

module fcf_cell #(
    parameter int TAPS        = fcf_pkg::TAPS_DEFAULT,
    parameter int SAMPLE_BITS = fcf_pkg::SAMPLE_BITS_DEFAULT,
    parameter int IDX         = 0
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic signed [fcf_pkg::COEF_BITS-1:0]   coef,
    input  fcf_pkg::xfer_ctl_t                     up_ctl,
    input  logic [fcf_pkg::OUT_BITS-1:0]           up_sum,
    input  logic [TAPS-1:0][SAMPLE_BITS-1:0]       up_taps,
    output logic                                   up_ready,
    input  logic                                   down_ready,
    output fcf_pkg::xfer_ctl_t                     dn_ctl,
    output logic [fcf_pkg::OUT_BITS-1:0]           dn_sum,
    output logic [TAPS-1:0][SAMPLE_BITS-1:0]       dn_taps
);

    localparam int PROD_W = fcf_pkg::COEF_BITS + SAMPLE_BITS;
    localparam int EXT_W  = (PROD_W > fcf_pkg::OUT_BITS) ? PROD_W : fcf_pkg::OUT_BITS;

    fcf_pkg::xfer_ctl_t               ctl_reg;
    logic [fcf_pkg::OUT_BITS-1:0]     sum_reg;
    logic [fcf_pkg::OUT_BITS-1:0]     sum_next;
    logic [TAPS-1:0][SAMPLE_BITS-1:0] taps_reg;
    logic signed [SAMPLE_BITS-1:0]    tap;
    logic signed [PROD_W-1:0]         prod;
    logic signed [EXT_W-1:0]          prod_ext;
    logic                             load;

    assign tap      = up_taps[IDX];
    assign prod     = coef * tap;
    assign prod_ext = EXT_W'(prod);
    assign sum_next = up_sum + prod_ext[fcf_pkg::OUT_BITS-1:0];

    // Take a new transaction when empty or when the held one moves on.
    assign load     = !ctl_reg.valid || down_ready;
    assign up_ready = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (load)
        begin
            ctl_reg <= up_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sum_reg  <= sum_next;
            taps_reg <= up_taps;
        end
    end

    assign dn_ctl  = ctl_reg;
    assign dn_sum  = sum_reg;
    assign dn_taps = taps_reg;

endmodule

### verif/tb_top.sv
// Self-checking testbench for the streaming 4-tap full-convolution FIR.
`timescale 1ns / 1ps

module tb_top;

    localparam int TAPS           = fcf_pkg::TAPS_DEFAULT;
    localparam int SAMPLE_BITS    = fcf_pkg::SAMPLE_BITS_DEFAULT;
    localparam int COEF_BITS      = fcf_pkg::COEF_BITS;
    localparam int OUT_BITS       = fcf_pkg::OUT_BITS;
    localparam int CFG_INDEX_BITS = fcf_pkg::CFG_INDEX_BITS;
    localparam int NUM_REG_SLOTS  = 1 << CFG_INDEX_BITS;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int MAX_REPORTS    = 40;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX =
        SAMPLE_BITS'(2 ** (SAMPLE_BITS - 1) - 1);
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN =
        SAMPLE_BITS'(-(2 ** (SAMPLE_BITS - 1)));
    localparam logic signed [COEF_BITS-1:0]   WEIGHT_MAX =
        COEF_BITS'(2 ** (COEF_BITS - 1) - 1);
    localparam logic signed [COEF_BITS-1:0]   WEIGHT_MIN =
        COEF_BITS'(-(2 ** (COEF_BITS - 1)));

    // Coefficient register map: register i holds the weight for delay i.
    typedef enum int {
        REG_COEF_0 = 0,
        REG_COEF_1 = 1,
        REG_COEF_2 = 2,
        REG_COEF_3 = 3
    } coef_reg_t;

    // One filter output as seen on the result channel.
    typedef struct {
        logic signed [OUT_BITS-1:0] filtered;
        logic                       last_out;
    } fir_result_t;

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic                             clk;
    logic                             rst_n;
    logic                             cfg_we;
    logic [CFG_INDEX_BITS-1:0]        cfg_index;
    logic [COEF_BITS-1:0]             cfg_data;
    logic                             in_valid;
    logic                             in_stall;
    logic signed [SAMPLE_BITS-1:0]    sample;
    logic                             block_end;
    logic                             out_valid;
    logic                             out_stall;
    logic signed [OUT_BITS-1:0]       filtered;
    logic                             last_out;

    // ------------------------------------------------------------------
    // Predictor state: kernel weights and the delay line of past samples,
    // newest first. Results predicted but not yet seen wait in order.
    // ------------------------------------------------------------------
    logic signed [COEF_BITS-1:0]      kernel [TAPS];
    logic signed [SAMPLE_BITS-1:0]    delay_line [TAPS-1];
    fir_result_t                      pending_outputs [$];

    int                               mismatch_count = 0;
    int unsigned                      cycle_count = 0;

    // Idling controls shared between the test sequence, the input tasks
    // and the output channel process.
    bit                               in_gaps_on = 0;
    bit                               out_stalls_on = 0;
    int                               hold_request = 0;

    full_convolution_fir_4tap_top #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .block_end (block_end),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .filtered  (filtered),
        .last_out  (last_out)
    );

    // ------------------------------------------------------------------
    // Clock: 8 ns period.
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: count cycles and stop a hung run.
    // ------------------------------------------------------------------
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Mismatch reporting: print one line (up to a cap) and count.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_REPORTS)
        begin
            $display("MISMATCH @%0t: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Exact sum of products for the current sample against the delay line,
    // kept to the low OUT_BITS bits.
    function automatic logic signed [OUT_BITS-1:0] conv_sum(
        input logic signed [SAMPLE_BITS-1:0] x
    );
        longint acc;
        acc = longint'(kernel[0]) * longint'(x);
        for (int k = 1; k < TAPS; k++)
        begin
            acc += longint'(kernel[k]) * longint'(delay_line[k-1]);
        end
        return acc[OUT_BITS-1:0];
    endfunction

    // Push a sample into the delay line, dropping the oldest.
    function automatic void shift_delay_line(input logic signed [SAMPLE_BITS-1:0] x);
        for (int k = TAPS - 2; k > 0; k--)
        begin
            delay_line[k] = delay_line[k-1];
        end
        if (TAPS > 1)
        begin
            delay_line[0] = x;
        end
    endfunction

    // Work out every result one accepted transaction causes and queue them.
    // A block end adds the tail results with zeros shifted in, flags the
    // final one, and leaves the delay line cleared.
    function automatic void predict_transaction(
        input logic signed [SAMPLE_BITS-1:0] x,
        input logic                          is_end
    );
        fir_result_t r;
        r.filtered = conv_sum(x);
        r.last_out = is_end && (TAPS == 1);
        pending_outputs.push_back(r);
        shift_delay_line(x);
        if (is_end)
        begin
            for (int t = 0; t < TAPS - 1; t++)
            begin
                r.filtered = conv_sum('0);
                r.last_out = (t == TAPS - 2);
                pending_outputs.push_back(r);
                shift_delay_line('0);
            end
            for (int k = 0; k < TAPS - 1; k++)
            begin
                delay_line[k] = '0;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Random value helpers
    // ------------------------------------------------------------------

    // Idle length: mostly none, often a few cycles, now and then a long one.
    function automatic int pick_idle_len();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 60)
        begin
            return 0;
        end
        else if (r < 93)
        begin
            return int'($urandom_range(1, 3));
        end
        return int'($urandom_range(8, 40));
    endfunction

    // Sample mix: full range, the extremes and zero, and small values.
    function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 70)
        begin
            return SAMPLE_BITS'($urandom());
        end
        else if (r < 85)
        begin
            unique case ($urandom_range(0, 3))
                0:       return SAMPLE_MAX;
                1:       return SAMPLE_MIN;
                2:       return '0;
                default: return '1;
            endcase
        end
        return SAMPLE_BITS'(int'($urandom_range(0, 15)) - 8);
    endfunction

    function automatic logic signed [COEF_BITS-1:0] random_weight();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 75)
        begin
            return COEF_BITS'($urandom());
        end
        else if (r < 90)
        begin
            return ($urandom_range(0, 1) == 1) ? WEIGHT_MAX : WEIGHT_MIN;
        end
        return COEF_BITS'(int'($urandom_range(0, 31)) - 16);
    endfunction

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------

    // Drive one register write; the next write or cfg_release drops it.
    task automatic cfg_write(input int idx, input logic [COEF_BITS-1:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx[CFG_INDEX_BITS-1:0];
        cfg_data  = value;
        // Slots beyond the kernel length are ignored by the block.
        if (idx < TAPS)
        begin
            kernel[idx] = value;
        end
    endtask

    task automatic cfg_release();
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Load a full kernel, plus one write to an unused slot that must have
    // no effect. Call only while the filter is idle.
    task automatic program_kernel(
        input logic signed [COEF_BITS-1:0] w0,
        input logic signed [COEF_BITS-1:0] w1,
        input logic signed [COEF_BITS-1:0] w2,
        input logic signed [COEF_BITS-1:0] w3
    );
        cfg_write(REG_COEF_0, w0);
        cfg_write(REG_COEF_1, w1);
        cfg_write(REG_COEF_2, w2);
        cfg_write(REG_COEF_3, w3);
        cfg_write(int'($urandom_range(TAPS, NUM_REG_SLOTS - 1)), COEF_BITS'($urandom()));
        cfg_release();
    endtask

    // ------------------------------------------------------------------
    // Input channel
    // ------------------------------------------------------------------

    // Offer one sample, optionally after an idle gap, and hold it until
    // the block takes it. Valid stays high afterwards so back-to-back
    // transactions run at full rate.
    task automatic send_sample(
        input logic signed [SAMPLE_BITS-1:0] x,
        input logic                          is_end
    );
        int gap;
        gap = in_gaps_on ? pick_idle_len() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid  = 1'b1;
        sample    = x;
        block_end = is_end;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        predict_transaction(x, is_end);
    endtask

    // Send a block of random samples, flagging the last one.
    task automatic send_block(input int len);
        for (int i = 0; i < len; i++)
        begin
            send_sample(random_sample(), i == len - 1);
        end
    endtask

    // Drop valid, wait for every predicted result, then let the pipeline
    // settle for its latency before touching the configuration.
    task automatic wait_for_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_outputs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAPS + 2) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Output channel: random stall runs, plus a long hold on request.
    // Exactly one assignment to out_stall per falling edge.
    // ------------------------------------------------------------------
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            else if (stall_left == 0 && out_stalls_on && $urandom_range(0, 99) < 25)
            begin
                stall_left = pick_idle_len();
            end
            out_stall = (stall_left > 0);
            if (stall_left > 0)
            begin
                stall_left--;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each accepted result with the oldest
    // prediction, field by field.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        fir_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_outputs.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result filtered=%0d last_out=%0b",
                                          filtered, last_out));
            end
            else
            begin
                want = pending_outputs.pop_front();
                if (filtered !== want.filtered)
                begin
                    report_mismatch($sformatf("filtered: got %0d, want %0d",
                                              filtered, want.filtered));
                end
                if (last_out !== want.last_out)
                begin
                    report_mismatch($sformatf("last_out: got %0b, want %0b (filtered=%0d)",
                                              last_out, want.last_out, want.filtered));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Weights reset to zero: everything filters to zero, tail included.
    task automatic test_reset_state();
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(16'sd1234, 1'b1);
        wait_for_idle();
    endtask

    // An impulse returns the kernel; a short ramp checks tap alignment.
    task automatic test_impulse_response();
        program_kernel(16'sd1000, -16'sd2000, 16'sd3000, -16'sd4000);
        send_sample(16'sd1, 1'b1);
        send_sample(16'sd1, 1'b0);
        send_sample(16'sd2, 1'b0);
        send_sample(16'sd3, 1'b1);
        wait_for_idle();
    endtask

    // Drive the sum to both ends of its range.
    task automatic test_extreme_sums();
        // Largest positive sum: every product is (-2^15)*(-2^15).
        program_kernel(WEIGHT_MIN, WEIGHT_MIN, WEIGHT_MIN, WEIGHT_MIN);
        repeat (3) send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        wait_for_idle();

        // Most negative sum with positive weights.
        program_kernel(WEIGHT_MAX, WEIGHT_MAX, WEIGHT_MAX, WEIGHT_MAX);
        repeat (3) send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        wait_for_idle();

        // Alternating signs on both sides.
        program_kernel(WEIGHT_MAX, WEIGHT_MIN, WEIGHT_MAX, WEIGHT_MIN);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b1);
        wait_for_idle();
    endtask

    // Writes to every slot past the kernel must leave the weights alone.
    task automatic test_ignored_index();
        for (int idx = TAPS; idx < NUM_REG_SLOTS; idx++)
        begin
            cfg_write(idx, COEF_BITS'($urandom()));
        end
        cfg_release();
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(-16'sd7, 1'b1);
        wait_for_idle();
    endtask

    // Blocks of one sample each, back to back.
    task automatic test_single_sample_blocks();
        program_kernel(random_weight(), random_weight(), random_weight(), random_weight());
        send_sample(SAMPLE_MAX, 1'b1);
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample(-16'sd1, 1'b1);
        wait_for_idle();
    endtask

    // Random blocks: mostly short, some long. The last block may be cut
    // off so its history carries into the next phase.
    task automatic test_random_blocks(
        input int                          n_items,
        input logic signed [COEF_BITS-1:0] w0,
        input logic signed [COEF_BITS-1:0] w1,
        input logic signed [COEF_BITS-1:0] w2,
        input logic signed [COEF_BITS-1:0] w3
    );
        int sent;
        int len;
        sent = 0;
        program_kernel(w0, w1, w2, w3);
        while (sent < n_items)
        begin
            len = ($urandom_range(0, 9) < 8) ? int'($urandom_range(1, 8))
                                             : int'($urandom_range(9, 40));
            if (len > n_items - sent)
            begin
                for (int i = 0; i < n_items - sent; i++)
                begin
                    send_sample(random_sample(), 1'b0);
                end
                len = n_items - sent;
            end
            else
            begin
                send_block(len);
            end
            sent += len;
        end
        wait_for_idle();
    endtask

    // Hold the output off for a long stretch while the input keeps
    // offering samples at full rate, so the chain fills and stalls.
    task automatic test_output_backpressure();
        in_gaps_on    = 1'b0;
        out_stalls_on = 1'b0;
        program_kernel(random_weight(), random_weight(), random_weight(), random_weight());
        hold_request = 250;
        send_block(5);
        send_block(12);
        send_block(1);
        send_block(12);
        wait_for_idle();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        sample    = '0;
        block_end = 1'b0;
        for (int k = 0; k < TAPS; k++)
        begin
            kernel[k] = '0;
        end
        for (int k = 0; k < TAPS - 1; k++)
        begin
            delay_line[k] = '0;
        end

        // Hold reset, then release away from the rising edge.
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part runs at full rate with an open output.
        test_reset_state();
        test_impulse_response();
        test_extreme_sums();
        test_ignored_index();
        test_single_sample_blocks();

        // Random part: vary the idling on each side between phases.
        in_gaps_on    = 1'b1;
        out_stalls_on = 1'b1;
        test_random_blocks(60, random_weight(), random_weight(),
                           random_weight(), random_weight());
        in_gaps_on    = 1'b0;
        out_stalls_on = 1'b0;
        test_random_blocks(40, WEIGHT_MAX, WEIGHT_MAX, WEIGHT_MAX, WEIGHT_MAX);
        in_gaps_on    = 1'b1;
        out_stalls_on = 1'b0;
        test_random_blocks(40, WEIGHT_MIN, WEIGHT_MIN, WEIGHT_MIN, WEIGHT_MIN);
        in_gaps_on    = 1'b0;
        out_stalls_on = 1'b1;
        test_random_blocks(50, random_weight(), random_weight(),
                           random_weight(), random_weight());
        in_gaps_on    = 1'b1;
        out_stalls_on = 1'b1;
        test_random_blocks(60, random_weight(), random_weight(),
                           random_weight(), random_weight());

        test_output_backpressure();

        // Let the pipeline settle once more before the verdict.
        repeat (4 * TAPS) @(posedge clk);
        if (mismatch_count == 0 && pending_outputs.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
sv/fcf_pkg.sv
sv/fcf_feed.sv
sv/fcf_cell.sv
sv/full_convolution_fir_4tap_top.sv
verif/tb_top.sv
